@@ design/opd_pkg.sv @@
// Shared types, constants and codes for the oscillation period detector.
// Used by opd_ctrl, opd_dp and oscillation_period_detector_core; no dependencies.
package opd_pkg;

    // Field widths.
    localparam int MEAS_W     = 24;
    localparam int TS_W       = 32;
    localparam int ERR_W      = 25;
    localparam int LIM_W      = 26;
    localparam int OVER_W     = 23;
    localparam int CNT_W      = 7;
    localparam int TMO_W      = 20;
    localparam int PER_W      = 21;
    localparam int STAT_W     = 2;
    localparam int STEP_W     = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 32;

    // Angle constants in Q15.8: 180 and 360 degrees.
    localparam logic signed [ERR_W-1:0] HALF_TURN = 25'sd46080;
    localparam logic [ERR_W-1:0]        FULL_TURN = 25'd92160;

    // Restoring reduction over FULL_TURN << 7 .. FULL_TURN << 0.
    localparam int WRAP_STEPS = 8;
    localparam int WRAP_IDX_W = 3;
    // Quotient bits of the period division (dividend is 2 * span, 33 bits).
    localparam int DIV_W      = 33;
    localparam int DIV_STEPS  = 33;

    localparam logic [PER_W-1:0] PERIOD_MAX = 21'd2097151;

    // Register reset values.
    localparam logic [MEAS_W-1:0] TARGET_RST    = 24'd0;
    localparam logic [OVER_W-1:0] OVERSHOOT_RST = 23'd1536;
    localparam logic [CNT_W-1:0]  REQUIRED_RST  = 7'd4;
    localparam logic [TMO_W-1:0]  TIMEOUT_RST   = 20'd5000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET    = 3'd0,
        REG_OVERSHOOT = 3'd1,
        REG_REQUIRED  = 3'd2,
        REG_TIMEOUT   = 3'd3,
        REG_ANGULAR   = 3'd4
    } t_reg_idx;

    typedef enum logic [STAT_W-1:0] {
        STAT_RUNNING = 2'd0,
        STAT_PERIOD  = 2'd1,
        STAT_ABORTED = 2'd2,
        STAT_TIMEOUT = 2'd3
    } t_status;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_LOAD = 8'b0000_0010,
        ST_WRAP = 8'b0000_0100,
        ST_WFIX = 8'b0000_1000,
        ST_EVAL = 8'b0001_0000,
        ST_DIV  = 8'b0010_0000,
        ST_DFIN = 8'b0100_0000,
        ST_OUT  = 8'b1000_0000
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              capture;
        logic              load;
        logic              wrap_step;
        logic              wrap_fix;
        logic              eval;
        logic              div_step;
        logic              div_fin;
        logic              emit;
        logic [STEP_W-1:0] step;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_wrap;
        logic div_go;
    } t_dp_sts;

endpackage

@@ design/opd_ctrl.sv @@
// Sequencer of the oscillation period detector: one-hot state machine and step counter.
// Depends on opd_pkg; drives opd_dp through t_dp_cmd.
module opd_ctrl import opd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_valid,
    output logic    o_s_ready,
    output logic    o_m_valid,
    input  logic    i_m_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_m_valid, n_m_valid;

    always_comb begin
        n_state        = r_state;
        n_step         = r_step;
        n_m_valid      = r_m_valid & ~i_m_ready;
        o_cmd          = '0;
        o_cmd.step     = r_step;
        case (r_state)
            ST_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_LOAD;
                end
            end
            ST_LOAD: begin
                o_cmd.load = 1'b1;
                if (i_sts.need_wrap) begin
                    n_step  = STEP_W'(WRAP_STEPS - 1);
                    n_state = ST_WRAP;
                end else begin
                    n_state = ST_EVAL;
                end
            end
            ST_WRAP: begin
                o_cmd.wrap_step = 1'b1;
                if (r_step == '0) begin
                    n_state = ST_WFIX;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            ST_WFIX: begin
                o_cmd.wrap_fix = 1'b1;
                n_state        = ST_EVAL;
            end
            ST_EVAL: begin
                o_cmd.eval = 1'b1;
                if (i_sts.div_go) begin
                    n_step  = STEP_W'(DIV_STEPS - 1);
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_step == '0) begin
                    n_state = ST_DFIN;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            ST_DFIN: begin
                o_cmd.div_fin = 1'b1;
                n_state       = ST_OUT;
            end
            ST_OUT: begin
                // The result register is free when empty or drained this cycle.
                if (!r_m_valid || i_m_ready) begin
                    o_cmd.emit = 1'b1;
                    n_m_valid  = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_step    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_step    <= n_step;
            r_m_valid <= n_m_valid;
        end
    end

    assign o_s_ready = (r_state == ST_IDLE);
    assign o_m_valid = r_m_valid;

endmodule

@@ design/opd_dp.sv @@
// Datapath of the oscillation period detector: registers, error wrap, trial state,
// serial period divider and the result register. Depends on opd_pkg; run by opd_ctrl.
module opd_dp import opd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    input  logic                  i_cfg_wr,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_start,
    input  logic [MEAS_W-1:0]     i_meas,
    input  logic [TS_W-1:0]       i_ts,
    output logic [STAT_W-1:0]     o_status,
    output logic [PER_W-1:0]      o_period,
    output logic [CNT_W-1:0]      o_crossings
);

    // Configuration registers.
    logic signed [MEAS_W-1:0] r_target;
    logic [OVER_W-1:0]        r_over;
    logic [CNT_W-1:0]         r_required;
    logic [TMO_W-1:0]         r_timeout;
    logic                     r_angular;

    // Captured sample.
    logic                     r_start;
    logic signed [MEAS_W-1:0] r_meas;
    logic [TS_W-1:0]          r_ts;

    // Trial state.
    logic signed [ERR_W-1:0]  r_prev;
    logic [CNT_W-1:0]         r_count;
    logic [TS_W-1:0]          r_first;
    logic [TS_W-1:0]          r_last;
    logic [TS_W-1:0]          r_tstart;
    logic [STAT_W-1:0]        r_status;
    logic [PER_W-1:0]         r_held;

    // Working registers.
    logic signed [ERR_W-1:0]  r_err;
    logic signed [LIM_W-1:0]  r_limit;
    logic [ERR_W-1:0]         r_wrem;
    logic                     r_wneg;
    logic [DIV_W-1:0]         r_dq;
    logic [CNT_W-1:0]         r_rem;
    logic [CNT_W-1:0]         r_dvs;

    // Result register.
    logic [STAT_W-1:0]        r_o_status;
    logic [PER_W-1:0]         r_o_period;
    logic [CNT_W-1:0]         r_o_cross;

    logic signed [ERR_W-1:0]  err_c;
    logic signed [LIM_W-1:0]  tgt_l;
    logic signed [LIM_W-1:0]  tgt_abs;
    logic signed [LIM_W-1:0]  lim_c;
    logic [ERR_W-1:0]         wsub;
    logic [ERR_W-1:0]         wrem_nx;
    logic signed [ERR_W-1:0]  wfix_c;
    logic signed [LIM_W-1:0]  mag;
    logic [TS_W-1:0]          elapsed;
    logic                     timed_out;
    logic                     aborted;
    logic                     crossed;
    logic [CNT_W-1:0]         cnt_nx;
    logic [TS_W-1:0]          first_nx;
    logic [TS_W-1:0]          last_nx;
    logic [CNT_W-1:0]         req;
    logic                     div_go;
    logic [CNT_W:0]           dtrial;
    logic                     dge;
    logic [CNT_W:0]           ddiff;

    // Error and abort threshold, formed in the load cycle.
    assign err_c   = ERR_W'(r_target) - ERR_W'(r_meas);
    assign tgt_l   = LIM_W'(r_target);
    assign tgt_abs = r_target[MEAS_W-1] ? -tgt_l : tgt_l;
    assign lim_c   = LIM_W'($signed({1'b0, r_over})) + (r_angular ? tgt_abs : tgt_l);

    // One restoring step of the reduction modulo a full turn.
    assign wsub    = FULL_TURN << i_cmd.step[WRAP_IDX_W-1:0];
    assign wrem_nx = (r_wrem >= wsub) ? (r_wrem - wsub) : r_wrem;

    // Map the remainder back into the half-turn band; exact multiples land on the edge.
    always_comb begin
        if (r_wrem == '0) begin
            wfix_c = r_wneg ? -HALF_TURN : HALF_TURN;
        end else if (r_wneg) begin
            wfix_c = HALF_TURN - $signed(r_wrem);
        end else begin
            wfix_c = $signed(r_wrem) - HALF_TURN;
        end
    end

    // Evaluation of one sample.
    assign mag       = r_err[ERR_W-1] ? -LIM_W'(r_err) : LIM_W'(r_err);
    assign elapsed   = r_ts - r_tstart;
    assign timed_out = (elapsed >= TS_W'(r_timeout));
    assign aborted   = (mag > r_limit);
    assign crossed   = (r_prev != '0) && (r_err != '0) && (r_prev[ERR_W-1] != r_err[ERR_W-1]);
    assign cnt_nx    = crossed ? (r_count + 1'b1) : r_count;
    assign first_nx  = (crossed && (cnt_nx == CNT_W'(1))) ? r_ts : r_first;
    assign last_nx   = crossed ? r_ts : r_last;
    assign req       = (r_required < CNT_W'(2)) ? CNT_W'(2) : r_required;
    assign div_go    = (r_status == STAT_RUNNING) && !timed_out && !aborted && (cnt_nx >= req);

    // Restoring division step.
    assign dtrial = {r_rem, r_dq[DIV_W-1]};
    assign dge    = (dtrial >= {1'b0, r_dvs});
    assign ddiff  = dtrial - {1'b0, r_dvs};

    assign o_sts.need_wrap = r_angular && ((err_c > HALF_TURN) || (err_c < -HALF_TURN));
    assign o_sts.div_go    = div_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target   <= TARGET_RST;
            r_over     <= OVERSHOOT_RST;
            r_required <= REQUIRED_RST;
            r_timeout  <= TIMEOUT_RST;
            r_angular  <= 1'b0;
            r_prev     <= '0;
            r_count    <= '0;
            r_first    <= '0;
            r_last     <= '0;
            r_tstart   <= '0;
            r_status   <= STAT_RUNNING;
            r_held     <= '0;
        end else begin
            if (i_cfg_wr) begin
                case (i_cfg_index)
                    REG_TARGET:    r_target   <= i_cfg_data;
                    REG_OVERSHOOT: r_over     <= i_cfg_data[OVER_W-1:0];
                    REG_REQUIRED:  r_required <= i_cfg_data[CNT_W-1:0];
                    REG_TIMEOUT:   r_timeout  <= i_cfg_data[TMO_W-1:0];
                    REG_ANGULAR:   r_angular  <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.load && r_start) begin
                r_prev   <= ERR_W'(r_target);
                r_count  <= '0;
                r_first  <= '0;
                r_last   <= '0;
                r_tstart <= r_ts;
                r_status <= STAT_RUNNING;
                r_held   <= '0;
            end
            if (i_cmd.eval && (r_status == STAT_RUNNING)) begin
                if (timed_out) begin
                    r_status <= STAT_TIMEOUT;
                end else if (aborted) begin
                    r_status <= STAT_ABORTED;
                end else begin
                    r_count <= cnt_nx;
                    r_first <= first_nx;
                    r_last  <= last_nx;
                    r_prev  <= r_err;
                end
            end
            if (i_cmd.div_fin) begin
                r_status <= STAT_PERIOD;
                r_held   <= (r_dq[DIV_W-1:PER_W] != '0) ? PERIOD_MAX : r_dq[PER_W-1:0];
            end
        end
    end

    // Payload and working registers need no reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_start <= i_start;
            r_meas  <= i_meas;
            r_ts    <= i_ts;
        end
        if (i_cmd.load) begin
            r_err   <= err_c;
            r_limit <= lim_c;
            if (err_c > HALF_TURN) begin
                r_wrem <= err_c - HALF_TURN;
                r_wneg <= 1'b0;
            end else begin
                r_wrem <= -HALF_TURN - err_c;
                r_wneg <= 1'b1;
            end
        end
        if (i_cmd.wrap_step) begin
            r_wrem <= wrem_nx;
        end
        if (i_cmd.wrap_fix) begin
            r_err <= wfix_c;
        end
        if (i_cmd.eval) begin
            // The dividend is twice the span between first and last crossing.
            r_dq  <= {last_nx - first_nx, 1'b0};
            r_rem <= '0;
            r_dvs <= req - 1'b1;
        end
        if (i_cmd.div_step) begin
            r_dq  <= {r_dq[DIV_W-2:0], dge};
            r_rem <= dge ? ddiff[CNT_W-1:0] : dtrial[CNT_W-1:0];
        end
        if (i_cmd.emit) begin
            r_o_status <= r_status;
            r_o_period <= (r_status == STAT_PERIOD) ? r_held : '0;
            r_o_cross  <= r_count;
        end
    end

    assign o_status    = r_o_status;
    assign o_period    = r_o_period;
    assign o_crossings = r_o_cross;

endmodule

@@ design/oscillation_period_detector_core.sv @@
// A beat accepted in idle is captured, loaded and evaluated, then handed to the output
// register; an angular sample that needs wrapping adds 8 modulo steps and a fixup, and
// a sample that completes the period adds 33 divider steps and a saturate.
// No new beat is taken before the hand-off, which waits on the divider and m_tready.
// Reset (i_rst_n low, synchronous) restores register defaults and a fresh, running trial.
// Depends on opd_pkg, opd_ctrl and opd_dp.
module oscillation_period_detector_core import opd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write channel.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Sample stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,  // [23:0] measurement, [55:24] timestamp_ms
    input  logic                  s_tuser,  // [0] trial_start
    // Result stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata   // [1:0] status, [22:2] period_ms,
                                            // [29:23] crossings, [31:30] zero
);

    t_dp_cmd           cmd;
    t_dp_sts           sts;
    logic [STAT_W-1:0] status;
    logic [PER_W-1:0]  period;
    logic [CNT_W-1:0]  crossings;

    // Always taken; the host must write them only while idle, unchecked by the block.
    assign o_cfg_ready = 1'b1;

    // The controller walks each beat through load, optional angle wrap, evaluation,
    // optional period division and hand-off to the output register.
    opd_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_tvalid),
        .o_s_ready (s_tready),
        .o_m_valid (m_tvalid),
        .i_m_ready (m_tready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    // The datapath holds the registers, the trial state and the result register, so a new
    // beat is taken while the previous result still waits downstream.
    opd_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_wr    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_start     (s_tuser),
        .i_meas      (s_tdata[MEAS_W-1:0]),
        .i_ts        (s_tdata[MEAS_W +: TS_W]),
        .o_status    (status),
        .o_period    (period),
        .o_crossings (crossings)
    );

    assign m_tdata = {2'b00, crossings, period, status};

    // A beat occupies the block: input is not taken again in the following cycle.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("sample accepted while previous sample in progress");

    // A period value only travels with the period-found status.
    a_period_only_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && (m_tdata[1:0] != STAT_PERIOD)) |-> (m_tdata[22:2] == '0))
        else $error("nonzero period without period-found status");

    // A result is loaded as the controller returns to idle.
    a_result_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_tvalid) |-> s_tready)
        else $error("result loaded without returning to idle");

endmodule
